@@ rtl/desc_pkg.sv @@
// Shared constants, types and helpers of the dual encoder step counter.
package desc_pkg;

    localparam int COUNT_MAX_DEF = 1023;

    // Field widths of the words on the two channels
    localparam int BTN_W   = 2;
    localparam int ENC_W   = 4;
    localparam int PH_W    = 2;
    localparam int VALUE_W = 10;
    localparam int DIGIT_W = 4;
    localparam int STEP_W  = 3;
    localparam int BAR_W   = 8;

    // Debounce shift register
    localparam int          DEB_W     = 16;
    localparam logic [15:0] DEB_FILL  = 16'hE000;
    localparam logic [15:0] DEB_PRESS = 16'hF000;

    // Quadrature phase codes
    localparam logic [PH_W-1:0] PH_REST = 2'd3;
    localparam logic [PH_W-1:0] PH_CW   = 2'd1;
    localparam logic [PH_W-1:0] PH_CCW  = 2'd2;

    // Reciprocals for exact division of values below 2**16
    localparam int          RECIP_W   = 17;
    localparam logic [16:0] RECIP_10  = 17'd52429;
    localparam int          SHIFT_10  = 19;
    localparam logic [16:0] RECIP_100 = 17'd83887;
    localparam int          SHIFT_100 = 23;
    localparam logic [16:0] RECIP_1K  = 17'd67109;
    localparam int          SHIFT_1K  = 26;
    localparam int          DEC_BASE  = 10;

    typedef logic [1:0]        t_mode;
    typedef logic [STEP_W-1:0] t_step;

    // Step per detent from the mode bits
    function automatic t_step step_of_mode(input t_mode mode);
        t_step step;
        unique case (mode)
            2'b00:   step = 3'd1;
            2'b01:   step = 3'd2;
            2'b10:   step = 3'd4;
            default: step = 3'd0;
        endcase
        return step;
    endfunction

endpackage

@@ rtl/desc_if.sv @@
// Channel interfaces of the dual encoder step counter.
interface desc_in_if;
    logic                           valid;
    logic                           ready;
    logic [desc_pkg::BTN_W-1:0]     button_pins;
    logic [desc_pkg::ENC_W-1:0]     encoder_pins;

    modport source (output valid, output button_pins, output encoder_pins, input ready);
    modport sink   (input valid, input button_pins, input encoder_pins, output ready);
endinterface

interface desc_out_if;
    logic                           valid;
    logic                           ready;
    logic [desc_pkg::VALUE_W-1:0]   count_value;
    logic [desc_pkg::DIGIT_W-1:0]   digit_ones;
    logic [desc_pkg::DIGIT_W-1:0]   digit_tens;
    logic [desc_pkg::DIGIT_W-1:0]   digit_hundreds;
    logic                           digit_thousands;
    logic [desc_pkg::STEP_W-1:0]    step_size;
    logic [desc_pkg::BAR_W-1:0]     bargraph_byte;

    modport source (output valid, output count_value, output digit_ones, output digit_tens,
                    output digit_hundreds, output digit_thousands, output step_size,
                    output bargraph_byte, input ready);
    modport sink   (input valid, input count_value, input digit_ones, input digit_tens,
                    input digit_hundreds, input digit_thousands, input step_size,
                    input bargraph_byte, output ready);
endinterface

@@ rtl/dual_encoder_step_counter.sv @@
// A result word passes from the state registers through the quotient registers into the output register.
// Throughput: one word per cycle; state updates in the cycle of acceptance,
// then a quotient stage and a digit stage feed the output register.
// Backpressure stalls the stages from the output back to the input.
// Reset (synchronous, active low) clears debouncers, mode bits and phases,
// sets the step to 1, arms the first-tick flag and empties the pipeline.
module dual_encoder_step_counter #(
    parameter int COUNT_MAX = desc_pkg::COUNT_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    desc_in_if.sink     i_in,
    desc_out_if.source  o_out
);
    import desc_pkg::*;

    localparam int CW = $clog2(COUNT_MAX + 1);
    localparam int SW = CW + 5;

    logic                 in_acc;
    logic                 dig_ready;

    logic                 r_st_vld;
    logic [DEB_W-1:0]     r_hist0;
    logic [DEB_W-1:0]     r_hist1;
    t_mode                r_mode;
    t_step                r_step;
    logic [PH_W-1:0]      r_ph0;
    logic [PH_W-1:0]      r_ph1;
    logic                 r_first;
    logic [CW-1:0]        r_counter;

    logic [DEB_W-1:0]     n_hist0;
    logic [DEB_W-1:0]     n_hist1;
    logic [1:0]           press;
    t_mode                n_mode;
    t_step                n_step;
    logic [PH_W-1:0]      ph0;
    logic [PH_W-1:0]      ph1;
    logic signed [SW-1:0] step_s;
    logic signed [SW-1:0] mv0;
    logic signed [SW-1:0] mv1;
    logic signed [SW-1:0] sum;
    logic [CW-1:0]        n_counter;

    assign in_acc     = i_in.valid && i_in.ready;
    assign i_in.ready = !r_st_vld || dig_ready;

    // Debounce and mode toggles
    assign n_hist0 = {r_hist0[DEB_W-2:0], i_in.button_pins[0]} | DEB_FILL;
    assign n_hist1 = {r_hist1[DEB_W-2:0], i_in.button_pins[1]} | DEB_FILL;
    assign press   = {n_hist1 == DEB_PRESS, n_hist0 == DEB_PRESS};
    assign n_mode  = r_mode ^ press;
    assign n_step  = (press != 2'b00) ? step_of_mode(n_mode) : r_step;

    // Encoder moves, signed by direction
    assign ph0    = i_in.encoder_pins[PH_W-1:0];
    assign ph1    = i_in.encoder_pins[2*PH_W-1:PH_W];
    assign step_s = signed'(SW'(n_step));

    always_comb begin
        mv0 = '0;
        mv1 = '0;
        if (r_ph0 == PH_REST && ph0 == PH_CW) begin
            mv0 = step_s;
        end else if (r_ph0 == PH_REST && ph0 == PH_CCW) begin
            mv0 = -step_s;
        end
        if (r_ph1 == PH_REST && ph1 == PH_CW) begin
            mv1 = step_s;
        end else if (r_ph1 == PH_REST && ph1 == PH_CCW) begin
            mv1 = -step_s;
        end
    end

    // Wrap below zero to the top, above the top to zero; the first word after reset keeps the count
    assign sum = signed'(SW'(r_counter)) + mv0 + mv1;

    always_comb begin
        priority if (r_first) begin
            n_counter = r_counter;
        end else if (sum < 0) begin
            n_counter = CW'(COUNT_MAX);
        end else if (sum > signed'(SW'(COUNT_MAX))) begin
            n_counter = '0;
        end else begin
            n_counter = CW'(sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_vld  <= 1'b0;
            r_hist0   <= '0;
            r_hist1   <= '0;
            r_mode    <= '0;
            r_step    <= STEP_W'(1);
            r_ph0     <= '0;
            r_ph1     <= '0;
            r_first   <= 1'b1;
            r_counter <= '0;
        end else begin
            if (in_acc) begin
                r_st_vld  <= 1'b1;
                r_hist0   <= n_hist0;
                r_hist1   <= n_hist1;
                r_mode    <= n_mode;
                r_step    <= n_step;
                r_ph0     <= ph0;
                r_ph1     <= ph1;
                r_first   <= 1'b0;
                r_counter <= n_counter;
            end else if (dig_ready) begin
                r_st_vld  <= 1'b0;
            end
        end
    end

    desc_digits #(
        .CW (CW)
    ) u_digits (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_st_vld),
        .o_ready (dig_ready),
        .i_value (r_counter),
        .i_step  (r_step),
        .i_mode  (r_mode),
        .o_out   (o_out)
    );

endmodule

@@ rtl/desc_digits.sv @@
// Two-stage decimal split and display formatting of the counter value.
module desc_digits #(
    parameter int CW = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [CW-1:0]        i_value,
    input  desc_pkg::t_step      i_step,
    input  desc_pkg::t_mode      i_mode,
    desc_out_if.source           o_out
);
    import desc_pkg::*;

    localparam int PW = CW + RECIP_W;
    localparam int EW = CW + VALUE_W;
    localparam int DW = CW + DIGIT_W;

    logic          q_adv;
    logic          out_adv;
    logic [PW-1:0] prod_10;
    logic [PW-1:0] prod_100;
    logic [PW-1:0] prod_1k;

    logic          r_q_vld;
    logic [CW-1:0] r_value;
    logic [CW-1:0] r_q10;
    logic [CW-1:0] r_q100;
    logic [CW-1:0] r_q1k;
    t_step         r_step;
    t_mode         r_mode;

    logic [EW-1:0] value_ext;
    logic [DW-1:0] rem_ones;
    logic [DW-1:0] rem_tens;
    logic [DW-1:0] rem_hund;

    logic               r_out_vld;
    logic [VALUE_W-1:0] r_count;
    logic [DIGIT_W-1:0] r_ones;
    logic [DIGIT_W-1:0] r_tens;
    logic [DIGIT_W-1:0] r_hund;
    logic               r_thou;
    t_step              r_step_o;
    logic [BAR_W-1:0]   r_bar;

    assign out_adv = !r_out_vld || o_out.ready;
    assign q_adv   = !r_q_vld || out_adv;
    assign o_ready = q_adv;

    // Quotients by 10, 100 and 1000 in parallel
    assign prod_10  = PW'(i_value) * PW'(RECIP_10);
    assign prod_100 = PW'(i_value) * PW'(RECIP_100);
    assign prod_1k  = PW'(i_value) * PW'(RECIP_1K);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_vld <= 1'b0;
        end else if (q_adv) begin
            r_q_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_adv && i_valid) begin
            r_value <= i_value;
            r_q10   <= CW'(prod_10 >> SHIFT_10);
            r_q100  <= CW'(prod_100 >> SHIFT_100);
            r_q1k   <= CW'(prod_1k >> SHIFT_1K);
            r_step  <= i_step;
            r_mode  <= i_mode;
        end
    end

    // Each digit is one quotient less ten times the next
    assign value_ext = EW'(r_value);
    assign rem_ones  = DW'(r_value) - DW'(r_q10) * DW'(DEC_BASE);
    assign rem_tens  = DW'(r_q10) - DW'(r_q100) * DW'(DEC_BASE);
    assign rem_hund  = DW'(r_q100) - DW'(r_q1k) * DW'(DEC_BASE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_adv) begin
            r_out_vld <= r_q_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_q_vld) begin
            r_count  <= value_ext[VALUE_W-1:0];
            r_ones   <= rem_ones[DIGIT_W-1:0];
            r_tens   <= rem_tens[DIGIT_W-1:0];
            r_hund   <= rem_hund[DIGIT_W-1:0];
            r_thou   <= r_q1k[0];
            r_step_o <= r_step;
            r_bar    <= {value_ext[BAR_W-1:2], r_mode};
        end
    end

    assign o_out.valid           = r_out_vld;
    assign o_out.count_value     = r_count;
    assign o_out.digit_ones      = r_ones;
    assign o_out.digit_tens      = r_tens;
    assign o_out.digit_hundreds  = r_hund;
    assign o_out.digit_thousands = r_thou;
    assign o_out.step_size       = r_step_o;
    assign o_out.bargraph_byte   = r_bar;

endmodule

@@ rtl/desc_chk.sv @@
// Port-level checks of the dual encoder step counter, bound to the top level.
module desc_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [9:0] i_count_value,
    input logic [3:0] i_digit_ones,
    input logic [3:0] i_digit_tens,
    input logic [3:0] i_digit_hundreds,
    input logic       i_digit_thousands,
    input logic [2:0] i_step_size,
    input logic [7:0] i_bargraph_byte
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
            && $stable(i_count_value) && $stable(i_bargraph_byte)
            && $stable(i_step_size) && $stable(i_digit_ones)
            && $stable(i_digit_tens) && $stable(i_digit_hundreds)
            && $stable(i_digit_thousands))
        else $error("result word changed while stalled");

    // Drop any result after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_digit_ones <= 4'd9 && i_digit_tens <= 4'd9
            && i_digit_hundreds <= 4'd9)
        else $error("decimal digit out of range");

    // Bargraph carries the count above the two mode bits; step is a power of two or zero
    a_bar_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_bargraph_byte[7:2] == i_count_value[7:2]
            && (i_step_size == 3'd0 || i_step_size == 3'd1
                || i_step_size == 3'd2 || i_step_size == 3'd4))
        else $error("bargraph or step inconsistent with count");

endmodule

bind dual_encoder_step_counter desc_chk u_desc_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_count_value     (o_out.count_value),
    .i_digit_ones      (o_out.digit_ones),
    .i_digit_tens      (o_out.digit_tens),
    .i_digit_hundreds  (o_out.digit_hundreds),
    .i_digit_thousands (o_out.digit_thousands),
    .i_step_size       (o_out.step_size),
    .i_bargraph_byte   (o_out.bargraph_byte)
);
